FILE: design/sbwc_pkg.sv
package sbwc_pkg;

	localparam int MAX_BUCKETS_DEF = 16;
	localparam int TGT_CNT_DEF     = 32;

	localparam logic [31:0] LENGTH_RST = 32'd50000;
	localparam logic [31:0] STEP_RST   = 32'd10000;

	// request opcodes
	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_RECORD = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;  // unused, answered as a query

	// register indexes (paddr[2])
	localparam logic REG_LENGTH = 1'b0;
	localparam logic REG_STEP   = 1'b1;

	typedef struct packed {
		logic load_item;
		logic decode;
		logic clr_start;
		logic clr_step;
		logic adv_rd;
		logic adv_wr;
		logic scan_start;
		logic scan_rd;
		logic scan_chk;
		logic sum_start;
		logic sum_rd;
		logic out_load;
	} sbwc_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       new_chrom;
		logic       brk;
		logic       in_win;
		logic       clr_last;
		logic       hit;
		logic       scan_last;
		logic       sum_last;
		logic       out_free;
	} sbwc_sts_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] a);
		return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
	endfunction

endpackage

FILE: design/sbwc_ctrl.sv
module sbwc_ctrl import sbwc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sbwc_sts_t sts,
	output sbwc_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_BOOT, S_BOOT_CLR, S_IDLE, S_DEC, S_CLR, S_ADV,
		S_SCAN_RD, S_SCAN_CHK, S_SUM, S_SUM_END, S_DONE
	} state_t;

	state_t state_q;

	always_comb begin
		cmd      = '0;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_BOOT:     cmd.clr_start = 1'b1;
			S_BOOT_CLR: cmd.clr_step = 1'b1;
			S_IDLE:     cmd.load_item = in_valid;
			S_DEC: begin
				cmd.decode = 1'b1;
				if (sts.cmd == CMD_START) begin
					cmd.clr_start = sts.new_chrom;
					cmd.adv_rd    = !sts.new_chrom;
				end else if (sts.cmd == CMD_RECORD && !sts.brk && sts.in_win) begin
					cmd.scan_start = 1'b1;
				end else begin
					cmd.sum_start = 1'b1;
				end
			end
			S_CLR: begin
				cmd.clr_step  = 1'b1;
				cmd.sum_start = sts.clr_last;
			end
			S_ADV: begin
				cmd.adv_wr    = 1'b1;
				cmd.sum_start = 1'b1;
			end
			S_SCAN_RD:  cmd.scan_rd = 1'b1;
			S_SCAN_CHK: begin
				cmd.scan_chk  = 1'b1;
				cmd.sum_start = sts.hit || sts.scan_last;
			end
			S_SUM:      cmd.sum_rd = 1'b1;
			S_SUM_END:  cmd = '0;
			S_DONE:     cmd.out_load = sts.out_free;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT;
		end else begin
			unique case (state_q)
				S_BOOT:     state_q <= S_BOOT_CLR;
				S_BOOT_CLR: if (sts.clr_last) state_q <= S_IDLE;
				S_IDLE:     if (in_valid) state_q <= S_DEC;
				S_DEC: begin
					if (sts.cmd == CMD_START) begin
						state_q <= sts.new_chrom ? S_CLR : S_ADV;
					end else if (sts.cmd == CMD_RECORD && !sts.brk && sts.in_win) begin
						state_q <= S_SCAN_RD;
					end else begin
						state_q <= S_SUM;
					end
				end
				S_CLR:      if (sts.clr_last) state_q <= S_SUM;
				S_ADV:      state_q <= S_SUM;
				S_SCAN_RD:  state_q <= S_SCAN_CHK;
				S_SCAN_CHK: state_q <= (sts.hit || sts.scan_last) ? S_SUM : S_SCAN_RD;
				S_SUM:      if (sts.sum_last) state_q <= S_SUM_END;
				S_SUM_END:  state_q <= S_DONE;
				S_DONE:     if (sts.out_free) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: design/sbwc_dp.sv
module sbwc_dp import sbwc_pkg::*; #(
	parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
	parameter int TGT_CNT     = TGT_CNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  sbwc_cmd_t   cmd_i,
	output sbwc_sts_t   sts,
	input  logic [31:0] len,
	input  logic [31:0] step,
	input  logic [1:0]  cmd,
	input  logic [15:0] chrom_id,
	input  logic [31:0] position,
	input  logic        is_reference,
	input  logic [31:0] nonref_mask,
	input  logic [4:0]  individual,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        break_needed,
	output logic        recorded,
	output logic [31:0] span_start,
	output logic [31:0] span_end,
	output logic [31:0] total_sites,
	output logic [31:0] reference_sites,
	output logic [31:0] individual_sites
);

	localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int CW = $clog2(MAX_BUCKETS + 1);
	localparam int AW = 33 + BW;
	localparam int TW = (TGT_CNT > 1) ? $clog2(TGT_CNT) : 1;

	typedef struct packed {
		logic [31:0]              lower;
		logic [31:0]              sites;
		logic [31:0]              refs;
		logic [TGT_CNT-1:0][31:0] ind;
	} row_t;

	row_t mem [MAX_BUCKETS];
	row_t rd_q, wr_row;
	logic          wr_en;
	logic [BW-1:0] wr_addr, rd_addr;

	// request held for the whole operation
	logic [1:0]  cmd_q;
	logic [15:0] chrom_q;
	logic [31:0] pos_q;
	logic        isref_q;
	logic [31:0] mask_q;
	logic [4:0]  indiv_q;

	logic [15:0]   cur_chrom_q;
	logic          chrom_valid_q;
	logic [31:0]   win_start_q, win_end_q;
	logic [BW-1:0] oldest_q, idx_q, scan_b_q, scan_i_q;
	logic [CW-1:0] num_q, cnt_q;
	logic [AW-1:0] acc_q;
	logic          brk_q, rec_q, sum_vld_q;
	logic [31:0]   tot_q, refs_q, ind_q;

	logic [31:0]   st, lo_hi;
	logic [BW-1:0] newest, oldest_nx, scan_prev;
	logic [CW-1:0] cnt_nx;
	logic          hit;
	logic [31:0]   ind_pick;

	assign st = (step == 32'd0) ? 32'd1 : step;
	assign newest = (oldest_q == '0) ? BW'(num_q - CW'(1)) : oldest_q - BW'(1);
	assign oldest_nx = (({1'b0, oldest_q} + (BW+1)'(1)) == (BW+1)'(num_q)) ?
		'0 : oldest_q + BW'(1);
	assign scan_prev = (scan_b_q == '0) ? BW'(num_q - CW'(1)) : scan_b_q - BW'(1);
	assign cnt_nx = cnt_q + CW'(acc_q < AW'(len));
	assign lo_hi = rd_q.lower + st;
	assign hit = (rd_q.lower < pos_q) && (pos_q <= lo_hi);
	assign ind_pick = ({2'b0, indiv_q} < 7'(TGT_CNT)) ? rd_q.ind[TW'(indiv_q)] : 32'd0;

	always_comb begin
		sts.cmd       = cmd_q;
		sts.new_chrom = !chrom_valid_q || (chrom_q != cur_chrom_q);
		sts.brk       = sts.new_chrom || (pos_q > win_end_q);
		sts.in_win    = win_start_q < pos_q;
		sts.clr_last  = idx_q == BW'(MAX_BUCKETS - 1);
		sts.hit       = hit;
		sts.scan_last = ({1'b0, scan_i_q} + (BW+1)'(1)) == (BW+1)'(num_q);
		sts.sum_last  = idx_q == BW'(MAX_BUCKETS - 1);
		sts.out_free  = !out_valid || out_ready;
	end

	// memory port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = scan_b_q;
		wr_row  = rd_q;
		if (cmd_i.clr_step) begin
			wr_en   = 1'b1;
			wr_addr = idx_q;
			wr_row  = '0;
			wr_row.lower = acc_q[31:0];
		end else if (cmd_i.adv_wr) begin
			wr_en   = 1'b1;
			wr_addr = oldest_q;
			wr_row  = '0;
			wr_row.lower = lo_hi;
		end else if (cmd_i.scan_chk && hit) begin
			wr_en = 1'b1;
			wr_row.sites = sat_inc(rd_q.sites);
			if (isref_q) begin
				wr_row.refs = sat_inc(rd_q.refs);
			end else begin
				for (int t = 0; t < TGT_CNT; t++) begin
					if (t < 32 && mask_q[t[4:0]]) wr_row.ind[t] = sat_inc(rd_q.ind[t]);
				end
			end
		end
		if (cmd_i.sum_rd)      rd_addr = idx_q;
		else if (cmd_i.adv_rd) rd_addr = newest;
		else                   rd_addr = scan_b_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_row;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd_i.load_item) begin
			cmd_q   <= cmd;
			chrom_q <= chrom_id;
			pos_q   <= position;
			isref_q <= is_reference;
			mask_q  <= nonref_mask;
			indiv_q <= individual;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_chrom_q   <= '0;
			chrom_valid_q <= 1'b0;
			win_start_q   <= '0;
			win_end_q     <= '0;
			oldest_q      <= '0;
			num_q         <= CW'(1);
			cnt_q         <= '0;
			acc_q         <= '0;
			idx_q         <= '0;
			scan_b_q      <= '0;
			scan_i_q      <= '0;
			brk_q         <= 1'b0;
			rec_q         <= 1'b0;
			sum_vld_q     <= 1'b0;
			tot_q         <= '0;
			refs_q        <= '0;
			ind_q         <= '0;
			out_valid     <= 1'b0;
		end else begin
			if (cmd_i.decode) begin
				brk_q <= (cmd_q == CMD_RECORD) && sts.brk;
				rec_q <= 1'b0;
				if (cmd_q == CMD_START && sts.new_chrom) begin
					cur_chrom_q   <= chrom_q;
					chrom_valid_q <= 1'b1;
				end
			end
			// sweep index: a sweep start wins over a step
			if (cmd_i.clr_start || cmd_i.sum_start) idx_q <= '0;
			else if (cmd_i.clr_step || cmd_i.sum_rd) idx_q <= idx_q + BW'(1);
			if (cmd_i.clr_start) begin
				acc_q <= '0;
				cnt_q <= '0;
			end
			if (cmd_i.clr_step) begin
				acc_q <= acc_q + AW'(st);
				cnt_q <= cnt_nx;
				if (sts.clr_last) begin
					num_q       <= (cnt_nx == '0) ? CW'(1) : cnt_nx;
					win_start_q <= '0;
					win_end_q   <= len;
					oldest_q    <= '0;
				end
			end
			if (cmd_i.adv_wr) begin
				win_start_q <= win_start_q + st;
				win_end_q   <= win_end_q + st;
				oldest_q    <= oldest_nx;
			end
			if (cmd_i.scan_start) begin
				scan_b_q <= newest;
				scan_i_q <= '0;
			end
			if (cmd_i.scan_chk) begin
				if (hit) begin
					rec_q <= 1'b1;
				end else begin
					scan_b_q <= scan_prev;
					scan_i_q <= scan_i_q + BW'(1);
				end
			end
			if (cmd_i.sum_start) begin
				tot_q  <= '0;
				refs_q <= '0;
				ind_q  <= '0;
			end
			sum_vld_q <= cmd_i.sum_rd;
			if (sum_vld_q) begin
				tot_q  <= sat_add(tot_q, rd_q.sites);
				refs_q <= sat_add(refs_q, rd_q.refs);
				ind_q  <= sat_add(ind_q, ind_pick);
			end
			if (cmd_i.out_load)  out_valid <= 1'b1;
			else if (out_ready)  out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.out_load) begin
			break_needed     <= brk_q;
			recorded         <= rec_q;
			span_start       <= win_start_q;
			span_end         <= win_end_q;
			total_sites      <= tot_q;
			reference_sites  <= refs_q;
			individual_sites <= ind_q;
		end
	end

endmodule

FILE: design/sliding_bucket_window_counter_core.sv
// channel   dir  handshake            payload
// in        in   in_valid/in_ready    cmd chrom_id position is_reference nonref_mask individual
// out       out  out_valid/out_ready  break_needed recorded span_start span_end
//                                     total_sites reference_sites individual_sites
// cfg       in   APB psel/penable     0x0 span length, 0x4 span step
//
// One request at a time through a bucket memory with one write and one read port (one row per bucket).
// Query: a summing sweep reads one row a cycle over all MAX_BUCKETS rows.
// Start: new chromosome adds a clear sweep over all MAX_BUCKETS rows; advance adds one row write.
// Record: adds a read and a check per bucket searched, newest first, up to the bucket count.
// After reset a clearing pass over all buckets runs before in_ready rises.
// A result waiting on out_ready holds the next result back, but a new request is taken.
module sliding_bucket_window_counter_core import sbwc_pkg::*; #(
	parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
	parameter int TGT_CNT     = TGT_CNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] chrom_id,
	input  logic [31:0] position,
	input  logic        is_reference,
	input  logic [31:0] nonref_mask,
	input  logic [4:0]  individual,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        break_needed,
	output logic        recorded,
	output logic [31:0] span_start,
	output logic [31:0] span_end,
	output logic [31:0] total_sites,
	output logic [31:0] reference_sites,
	output logic [31:0] individual_sites,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] len_q, step_q;
	sbwc_cmd_t   cmd_w;
	sbwc_sts_t   sts_w;

	// config registers; only paddr[2] selects, byte offsets ignored
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_STEP) ? step_q : len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LENGTH_RST;
			step_q <= STEP_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_LENGTH) len_q <= pwdata;
			else                        step_q <= pwdata;
		end
	end

	sbwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts_w),
		.cmd      (cmd_w)
	);

	sbwc_dp #(
		.MAX_BUCKETS (MAX_BUCKETS),
		.TGT_CNT     (TGT_CNT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_i            (cmd_w),
		.sts              (sts_w),
		.len              (len_q),
		.step             (step_q),
		.cmd              (cmd),
		.chrom_id         (chrom_id),
		.position         (position),
		.is_reference     (is_reference),
		.nonref_mask      (nonref_mask),
		.individual       (individual),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.break_needed     (break_needed),
		.recorded         (recorded),
		.span_start       (span_start),
		.span_end         (span_end),
		.total_sites      (total_sites),
		.reference_sites  (reference_sites),
		.individual_sites (individual_sites)
	);

endmodule

FILE: tb/tb_sliding_bucket_window_counter_core.sv
`timescale 1ns / 1ps

module tb_sliding_bucket_window_counter_core import sbwc_pkg::*; ();

	localparam int NB = 16;
	localparam int NT = 32;
	localparam int SETTLE = 60;       // longest request (record over 16 buckets) plus margin
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] chrom;
		logic [31:0] pos;
		logic        is_ref;
		logic [31:0] mask;
		logic [4:0]  indiv;
	} req_t;

	typedef struct packed {
		logic        brk;
		logic        rec;
		logic [31:0] ws;
		logic [31:0] we;
		logic [31:0] tot;
		logic [31:0] refs;
		logic [31:0] ind;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = CMD_QUERY;
	logic [15:0] chrom_id = '0;
	logic [31:0] position = '0;
	logic is_reference = 1'b0;
	logic [31:0] nonref_mask = '0;
	logic [4:0] individual = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic break_needed, recorded;
	logic [31:0] span_start, span_end, total_sites, reference_sites, individual_sites;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	sliding_bucket_window_counter_core dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// requests waiting for the driver, results waiting for the monitor
	req_t req_q[$];
	res_t expected_totals[$];
	req_t cur_req;
	int errors = 0;
	bit quiet = 0;     // no idling in the closing phase
	int in_gap = 0, out_gap = 0, idle_cycles = 0;

	// predictor state
	logic [31:0] cfg_len = LENGTH_RST, cfg_step = STEP_RST;
	logic [15:0] m_chrom;
	bit m_chrom_ok;
	logic [31:0] m_start, m_end;
	int m_oldest, m_nb;
	logic [31:0] m_lower[NB];
	logic [31:0] m_sites[NB];
	logic [31:0] m_refs[NB];
	logic [31:0] m_ind[NB][NT];

	function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [31:0] step_eff();
		return (cfg_step == 0) ? 32'd1 : cfg_step;
	endfunction

	function automatic void wipe_bucket(int b, logic [31:0] lo);
		m_lower[b] = lo;
		m_sites[b] = '0;
		m_refs[b] = '0;
		for (int t = 0; t < NT; t++) m_ind[b][t] = '0;
	endfunction

	function automatic void restart_window();
		logic [31:0] st, n;
		st = step_eff();
		n = cfg_len / st + 32'((cfg_len % st) != 0);
		m_nb = (n < 1) ? 1 : (n > NB) ? NB : int'(n);
		m_start = '0;
		m_end = cfg_len;
		m_oldest = 0;
		for (int i = 0; i < NB; i++) wipe_bucket(i, 32'(i) * st);
	endfunction

	function automatic res_t predict_counts(req_t r);
		res_t o;
		logic [31:0] st, lo;
		int b, newest;
		o = '0;
		st = step_eff();
		if (r.cmd == CMD_START) begin
			if (!m_chrom_ok || r.chrom != m_chrom) begin
				m_chrom = r.chrom;
				m_chrom_ok = 1;
				restart_window();
			end else begin
				newest = (m_oldest + m_nb - 1) % m_nb;
				lo = m_lower[newest] + st;
				m_start += st;
				m_end += st;
				wipe_bucket(m_oldest, lo);
				m_oldest = (m_oldest + 1) % m_nb;
			end
		end else if (r.cmd == CMD_RECORD) begin
			if (!m_chrom_ok || r.chrom != m_chrom || r.pos > m_end) begin
				o.brk = 1;
			end else if (m_start < r.pos) begin
				// newest bucket first, the first one that holds the site takes it
				for (int i = 0; i < m_nb; i++) begin
					b = (m_oldest + m_nb - 1 - i) % m_nb;
					lo = m_lower[b];
					if (lo >= r.pos || r.pos > 32'(lo + st)) continue;
					o.rec = 1;
					m_sites[b] = sat_sum(m_sites[b], 32'd1);
					if (r.is_ref) m_refs[b] = sat_sum(m_refs[b], 32'd1);
					else for (int t = 0; t < NT; t++)
						if (r.mask[t]) m_ind[b][t] = sat_sum(m_ind[b][t], 32'd1);
					break;
				end
			end
		end
		o.ws = m_start;
		o.we = m_end;
		for (int i = 0; i < NB; i++) begin
			o.tot = sat_sum(o.tot, m_sites[i]);
			o.refs = sat_sum(o.refs, m_refs[i]);
			o.ind = sat_sum(o.ind, m_ind[i][r.indiv]);
		end
		return o;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %h want %h", $time, what, got, want);
		errors++;
	endtask

	// request driver: the slot frees when the held request is taken
	always @(posedge clk) begin
		logic v;
		if (arst_n && (!in_valid || in_ready)) begin
			if (in_valid) expected_totals.push_back(predict_counts(cur_req));
			v = 0;
			if (in_gap > 0) begin
				in_gap--;
			end else if (req_q.size() > 0) begin
				cur_req = req_q.pop_front();
				{cmd, chrom_id, position, is_reference, nonref_mask, individual} <= cur_req;
				v = 1;
				if (!quiet && $urandom_range(0, 19) == 0) in_gap = $urandom_range(1, 11);
			end
			in_valid <= v;
		end
	end

	// result monitor with bursty back-pressure
	always @(posedge clk) begin
		res_t w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_totals.size() == 0) begin
					$display("%0t: result with nothing expected", $time);
					errors++;
				end else begin
					w = expected_totals.pop_front();
					if (break_needed !== w.brk)
						report("break_needed", 32'(break_needed), 32'(w.brk));
					if (recorded !== w.rec) report("recorded", 32'(recorded), 32'(w.rec));
					if (span_start !== w.ws) report("span_start", span_start, w.ws);
					if (span_end !== w.we) report("span_end", span_end, w.we);
					if (total_sites !== w.tot) report("total_sites", total_sites, w.tot);
					if (reference_sites !== w.refs)
						report("reference_sites", reference_sites, w.refs);
					if (individual_sites !== w.ind)
						report("individual_sites", individual_sites, w.ind);
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				out_gap = $urandom_range(0, 10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog: cycles with no handshake of any kind
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable) || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// stimulus-side view of the window, so that sites land inside it
	logic [15:0] g_chrom;
	bit g_ok = 0;
	logic [31:0] g_start, g_len;

	task automatic push_req(logic [1:0] c, logic [15:0] ch, logic [31:0] p, logic rf,
	                        logic [31:0] mk, logic [4:0] iv);
		req_t r;
		r = {c, ch, p, rf, mk, iv};
		req_q.push_back(r);
		if (c == CMD_START) begin
			if (!g_ok || ch != g_chrom) begin
				g_ok = 1;
				g_chrom = ch;
				g_start = '0;
				g_len = cfg_len;
			end else
				g_start += (cfg_step == 0) ? 32'd1 : cfg_step;
		end
	endtask

	task automatic cfg_write(logic idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_LENGTH) cfg_len = val;
		else cfg_step = val;
	endtask

	task automatic drain();
		while (req_q.size() != 0 || in_valid || expected_totals.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		logic [31:0] st, p;
		int k;
		for (int i = 0; i < n; i++) begin
			st = (cfg_step == 0) ? 32'd1 : cfg_step;
			k = $urandom_range(0, 99);
			if (k < 10) begin
				// mostly advance the window; now and then a new chromosome
				push_req(CMD_START, ($urandom_range(0, 4) == 0) ? 16'($urandom) : g_chrom,
				         $urandom, 1'($urandom), $urandom, 5'($urandom));
			end else if (k < 75) begin
				p = g_start + (($urandom_range(0, 9) == 0) ? 32'($urandom)
				    : $urandom_range(0, g_len) + (($urandom_range(0, 7) == 0) ?
				      $urandom_range(0, st) : 32'd0));
				push_req(CMD_RECORD, ($urandom_range(0, 14) == 0) ? 16'($urandom) : g_chrom,
				         p, $urandom_range(0, 2) == 0, $urandom, 5'($urandom));
			end else if (k < 95) begin
				push_req(CMD_QUERY, 16'($urandom), $urandom, 1'($urandom), $urandom,
				         5'($urandom));
			end else begin
				// unused opcode: answered by the block as a query
				push_req(CMD_NONE, 16'($urandom), $urandom, 1'($urandom), $urandom,
				         5'($urandom));
			end
		end
	endtask

	logic [31:0] lens[8] = '{32'd100, 32'd1, 32'd37, 32'd30, 32'd5,
	                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1000};
	logic [31:0] steps[8] = '{32'd10, 32'd1, 32'd5, 32'd0, 32'd50,
	                          32'hFFFF_FFFF, 32'h1000_0000, 32'd10};

	initial begin
		m_chrom = '0;
		m_chrom_ok = 0;
		restart_window();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: break before any chromosome, edges of the window, full masks
		push_req(CMD_RECORD, 16'h0, 32'd5, 1'b0, 32'hFFFF_FFFF, 5'd0);
		push_req(CMD_QUERY, 16'h0, 32'd0, 1'b0, 32'h0, 5'd31);
		push_req(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 5'd31);
		push_req(CMD_START, 16'hFFFF, 32'd0, 1'b0, 32'h0, 5'd0);
		push_req(CMD_RECORD, 16'hFFFF, 32'd0, 1'b0, 32'hFFFF_FFFF, 5'd0);
		push_req(CMD_RECORD, 16'hFFFF, 32'd1, 1'b0, 32'hFFFF_FFFF, 5'd31);
		push_req(CMD_RECORD, 16'hFFFF, 32'd50000, 1'b1, 32'h0, 5'd0);
		push_req(CMD_RECORD, 16'hFFFF, 32'd50001, 1'b0, 32'hFFFF_FFFF, 5'd0);
		push_req(CMD_RECORD, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'h1, 5'd0);
		push_req(CMD_RECORD, 16'h0001, 32'd100, 1'b0, 32'h1, 5'd0);
		push_req(CMD_RECORD, 16'hFFFF, 32'd10000, 1'b0, 32'h8000_0001, 5'd31);
		push_req(CMD_RECORD, 16'hFFFF, 32'd10001, 1'b0, 32'h0, 5'd0);
		push_req(CMD_START, 16'hFFFF, 32'd0, 1'b0, 32'h0, 5'd31);
		push_req(CMD_RECORD, 16'hFFFF, 32'd10000, 1'b0, 32'hFFFF_FFFF, 5'd31);
		push_req(CMD_RECORD, 16'hFFFF, 32'd60000, 1'b1, 32'h0, 5'd0);
		push_req(CMD_START, 16'hFFFF, 32'd0, 1'b0, 32'h0, 5'd0);
		push_req(CMD_QUERY, 16'hFFFF, 32'd0, 1'b0, 32'h0, 5'd31);
		push_req(CMD_START, 16'h0000, 32'd0, 1'b0, 32'h0, 5'd0);
		push_req(CMD_QUERY, 16'h0000, 32'd0, 1'b0, 32'h0, 5'd0);
		random_phase(200);
		drain();

		// sweep the register settings; each new chromosome latches the bucket count
		for (int ph = 0; ph < 8; ph++) begin
			cfg_write(REG_LENGTH, lens[ph]);
			cfg_write(REG_STEP, steps[ph]);
			if (ph == 7) quiet = 1;
			push_req(CMD_START, g_chrom + 16'd1, $urandom, 1'($urandom), $urandom,
			         5'($urandom));
			random_phase(175);
			drain();
		end

		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: filelist.f
design/sbwc_pkg.sv
design/sbwc_ctrl.sv
design/sbwc_dp.sv
design/sliding_bucket_window_counter_core.sv
tb/tb_sliding_bucket_window_counter_core.sv
